[sv/mkgc_pkg.sv]
// Shared types, constants and constant tables of the multi-knee gain computer.
package mkgc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KNEE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP_GAIN = 2'd1;

  localparam logic ACT_PROCESS    = 1'b0;
  localparam logic ACT_KNEE_WRITE = 1'b1;

  localparam int COUNT_W = 4;
  localparam int INDEX_W = 3;
  localparam int THR_W   = 16;
  localparam int SLOPE_W = 16;
  localparam int WIDTH_W = 14;
  localparam int LEFT_W  = 18;
  localparam int QUAD_W  = 24;
  localparam int CUM_W   = 24;
  localparam int GAIN_W  = 24;
  localparam int SEG_W   = 4;

  localparam int DB_PER_OCT_Q16 = 394566;
  localparam int OCT_PER_DB_Q20 = 174164;
  localparam logic signed [15:0] SILENCE_Q8 = -16'sd25600;
  localparam logic signed [52:0] SILENCE_Q16 = -53'sd6553600;
  localparam logic signed [52:0] GAIN_CLAMP = 53'sd1073741824;

  localparam logic [4:0] DIV_LAST  = 5'd24;
  localparam logic [4:0] ITER_LAST = 5'd15;

  typedef struct packed {
    logic signed [THR_W-1:0]   thr;
    logic signed [SLOPE_W-1:0] slope;
    logic        [WIDTH_W-1:0] hw;
    logic signed [LEFT_W-1:0]  left;
    logic        [QUAD_W-1:0]  quad;
  } knee_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_WSTORE, S_CRD0, S_CLAT0, S_CRD, S_CCALC,
    S_NORM, S_LOG, S_LSCALE, S_SRD, S_SCMP, S_KRD, S_KLAT, S_PLAT,
    S_ABOVE, S_QCOEF, S_T1, S_T2, S_U1, S_U2, S_U3,
    S_GAIN, S_G2, S_EXP, S_SCALE, S_SHIFT, S_DONE
  } state_e;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x, r, b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Roots 2^(2^-(k+1)) in Q.30, each the floor root of the one before.
  function automatic logic [15:0][31:0] exp_roots();
    logic [15:0][31:0] t;
    logic [63:0] c;
    c = isqrt64(64'd2 << 60);
    for (int k = 0; k < 16; k++) begin
      t[k] = c[31:0];
      c = isqrt64(c << 30);
    end
    return t;
  endfunction

  localparam logic [15:0][31:0] EXP_ROOT = exp_roots();

endpackage

[sv/multi_knee_gain_computer.sv]
// Multi-knee soft-knee compressor gain computer: knee table, log, gain and exp.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | in        | in_valid_i/in_ready_o | action, sample, envelope, knee fields
//  out     | out       | out_valid_o/out_ready_i | out_sample, applied_gain_db, segment
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A knee write item runs a 25-step divider, stores the knee, then refreshes the cumulative
// offset of each later table entry. A process item runs a one-bit-a-cycle normalize of the
// envelope, 16 squaring steps, a search over the active knees, the gain states and
// 16 exp steps, all on one shared multiplier and one memory read port.
// Reset clears control state only; the knee tables are undefined until written.
// Input is taken only in idle; a finished item waits in the output register.
module multi_knee_gain_computer
  import mkgc_pkg::*;
#(
  parameter int MAX_KNEES   = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [SAMPLE_BITS-1:0] envelope_i,
  input  logic        [INDEX_W-1:0]     knee_index_i,
  input  logic signed [THR_W-1:0]       knee_threshold_db_i,
  input  logic signed [SLOPE_W-1:0]     knee_slope_i,
  input  logic        [WIDTH_W-1:0]     knee_width_db_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o,
  output logic signed [GAIN_W-1:0]      applied_gain_db_o,
  output logic        [SEG_W-1:0]       segment_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic        [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IW = (MAX_KNEES > 1) ? $clog2(MAX_KNEES) : 1;
  localparam int CW = $clog2(MAX_KNEES + 1);
  localparam logic signed [65:0] SMAX = (66'sd1 <<< (SAMPLE_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] SMIN = -SMAX - 66'sd1;

  // Control state
  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] knee_count_q, knee_count_d;
  logic signed [15:0] makeup_q, makeup_d;

  // Item payload and working registers
  logic signed [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic [SAMPLE_BITS-1:0] norm_q, norm_d;
  logic [4:0] sh_q, sh_d;
  logic [4:0] cnt_q, cnt_d;
  logic [30:0] m_q, m_d;
  logic [15:0] frac_q, frac_d;
  logic signed [25:0] e_q, e_d;
  logic [CW-1:0] j_q, j_d, seg_q, seg_d, n_q, n_d, ci_q, ci_d;
  logic [IW-1:0] kidx_q, kidx_d;
  knee_t wk_q, wk_d, knee_q, knee_d;
  logic [24:0] div_q, div_d;
  logic [14:0] rem_q, rem_d;
  logic signed [THR_W-1:0] prev_thr_q, prev_thr_d;
  logic signed [SLOPE_W-1:0] prev_slope_q, prev_slope_d;
  logic signed [CUM_W-1:0] prev_cum_q, prev_cum_d, cum_q, cum_d;
  logic signed [SLOPE_W-1:0] p_q, p_d;
  logic signed [26:0] off_q, off_d;
  logic signed [35:0] qc_q, qc_d;
  logic signed [65:0] acc_q, acc_d;
  logic signed [39:0] inner_q, inner_d;
  logic signed [51:0] red_q, red_d;
  logic signed [52:0] g_q, g_d;
  logic signed [15:0] expo_q, expo_d;
  logic [15:0] f_q, f_d;
  logic [31:0] r_q, r_d;
  logic signed [65:0] y_q, y_d;
  logic signed [SAMPLE_BITS-1:0] res_sample_q, res_sample_d;
  logic signed [GAIN_W-1:0] res_gain_q, res_gain_d;
  logic [SEG_W-1:0] res_seg_q, res_seg_d;
  logic signed [SAMPLE_BITS-1:0] out_sample_q, out_sample_d;
  logic signed [GAIN_W-1:0] out_gain_q, out_gain_d;
  logic [SEG_W-1:0] out_seg_q, out_seg_d;

  // Knee memory, cumulative offset memory, shared read port
  knee_t mem_a [MAX_KNEES];
  logic signed [CUM_W-1:0] mem_b [MAX_KNEES];
  knee_t rdata_a_q;
  logic signed [CUM_W-1:0] rdata_b_q;
  logic rb_zero_q;
  logic [IW-1:0] raddr, waddr;
  logic we_a, we_b;
  knee_t wdata_a;
  logic signed [CUM_W-1:0] wdata_b;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  assign prod = mul_a * mul_b;

  assign in_ready_o        = (state_q == S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign out_sample_o      = out_sample_q;
  assign applied_gain_db_o = out_gain_q;
  assign segment_o         = out_seg_q;

  always_comb begin
    logic [15:0] dt;
    logic [31:0] sq;
    logic signed [22:0] lval;
    logic [CW-1:0] segn;
    logic signed [26:0] lb, hi_b;
    logic signed [25:0] csum;
    logic signed [65:0] sum;
    logic signed [52:0] g;
    logic signed [44:0] g8;
    logic signed [31:0] gc, g2;
    logic signed [16:0] sexp;
    logic [5:0] sh6;
    logic signed [65:0] yr;
    logic [CW-1:0] i0;

    state_d = state_q;
    out_valid_d = out_valid_q;
    knee_count_d = knee_count_q;
    makeup_d = makeup_q;
    smp_d = smp_q; norm_d = norm_q; sh_d = sh_q; cnt_d = cnt_q; m_d = m_q;
    frac_d = frac_q; e_d = e_q; j_d = j_q; seg_d = seg_q; n_d = n_q; ci_d = ci_q;
    kidx_d = kidx_q; wk_d = wk_q; knee_d = knee_q; div_d = div_q; rem_d = rem_q;
    prev_thr_d = prev_thr_q; prev_slope_d = prev_slope_q; prev_cum_d = prev_cum_q;
    cum_d = cum_q; p_d = p_q; off_d = off_q; qc_d = qc_q; acc_d = acc_q;
    inner_d = inner_q; red_d = red_q; g_d = g_q; expo_d = expo_q; f_d = f_q;
    r_d = r_q; y_d = y_q;
    res_sample_d = res_sample_q; res_gain_d = res_gain_q; res_seg_d = res_seg_q;
    out_sample_d = out_sample_q; out_gain_d = out_gain_q; out_seg_d = out_seg_q;
    raddr = '0; waddr = '0; we_a = 1'b0; we_b = 1'b0;
    wdata_a = wk_q; wdata_b = '0;
    mul_a = '0; mul_b = '0;
    dt = '0; sq = '0; lval = '0; segn = seg_q; lb = '0; hi_b = '0; csum = '0;
    sum = '0; g = '0; g8 = '0; gc = '0; g2 = '0; sexp = '0; sh6 = '0; yr = '0;
    i0 = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KNEE_COUNT:  knee_count_d = cfg_data_i[COUNT_W-1:0];
        CFG_MAKEUP_GAIN: makeup_d = $signed(cfg_data_i);
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          smp_d = sample_i;
          norm_d = envelope_i;
          sh_d = '0;
          if (action_i == ACT_KNEE_WRITE) begin
            if (32'(knee_index_i) < MAX_KNEES) begin
              kidx_d = IW'(knee_index_i);
              wk_d.thr = knee_threshold_db_i;
              wk_d.slope = knee_slope_i;
              wk_d.hw = knee_width_db_i;
              wk_d.left = (18'(knee_threshold_db_i) <<< 1)
                        - $signed({4'b0, knee_width_db_i});
              wk_d.quad = '0;
              div_d = 25'(1 << 24) + 25'(knee_width_db_i);
              rem_d = '0;
              cnt_d = '0;
              state_d = S_DIV;
            end
          end else begin
            if ({28'b0, knee_count_q} > 32'(MAX_KNEES)) begin
              n_d = CW'(MAX_KNEES);
            end else begin
              n_d = CW'(knee_count_q);
            end
            seg_d = '0;
            if (n_d == '0) begin
              // No knees: pass the sample through untouched
              res_sample_d = sample_i;
              res_gain_d = '0;
              res_seg_d = '0;
              state_d = S_DONE;
            end else if (envelope_i == '0) begin
              red_d = '0;
              state_d = S_GAIN;
            end else begin
              state_d = S_NORM;
            end
          end
        end
      end

      // Restoring divider for the quadratic coefficient, one bit a cycle
      S_DIV: begin
        dt = {rem_q, div_q[24]};
        if (dt >= {1'b0, wk_q.hw, 1'b0}) begin
          rem_d = 15'(dt - {1'b0, wk_q.hw, 1'b0});
          div_d = {div_q[23:0], 1'b1};
        end else begin
          rem_d = dt[14:0];
          div_d = {div_q[23:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_WSTORE;
        end
      end

      S_WSTORE: begin
        we_a = 1'b1;
        waddr = kidx_q;
        wdata_a.quad = (wk_q.hw == '0) ? '0 : div_q[QUAD_W-1:0];
        i0 = (kidx_q == '0) ? CW'(1) : CW'(kidx_q);
        ci_d = i0;
        if (32'(i0) >= MAX_KNEES) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_CRD0;
        end
      end

      S_CRD0: begin
        raddr = IW'(ci_q - 1'b1);
        state_d = S_CLAT0;
      end

      S_CLAT0: begin
        prev_thr_d = rdata_a_q.thr;
        prev_slope_d = rdata_a_q.slope;
        prev_cum_d = rb_zero_q ? '0 : rdata_b_q;
        state_d = S_CRD;
      end

      S_CRD: begin
        raddr = IW'(ci_q);
        state_d = S_CCALC;
      end

      // Advance the cumulative offset by one table entry
      S_CCALC: begin
        mul_a = 33'(prev_slope_q);
        mul_b = 33'(17'(rdata_a_q.thr) - 17'(prev_thr_q));
        csum = 26'(prev_cum_q) + 26'(prod >>> 14);
        if (csum > 26'sd8388607) begin
          wdata_b = 24'sh7FFFFF;
        end else if (csum < -26'sd8388608) begin
          wdata_b = -24'sd8388608;
        end else begin
          wdata_b = csum[23:0];
        end
        we_b = 1'b1;
        waddr = IW'(ci_q);
        prev_thr_d = rdata_a_q.thr;
        prev_slope_d = rdata_a_q.slope;
        prev_cum_d = wdata_b;
        ci_d = ci_q + 1'b1;
        if (32'(ci_q) + 1 >= MAX_KNEES) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_CRD;
        end
      end

      // Shift the envelope up until its leading one reaches the top
      S_NORM: begin
        if (norm_q[SAMPLE_BITS-1]) begin
          sq = 32'(norm_q) << (32 - SAMPLE_BITS);
          m_d = sq[31:1];
          cnt_d = '0;
          frac_d = '0;
          state_d = S_LOG;
        end else begin
          norm_d = norm_q << 1;
          sh_d = sh_q + 5'd1;
        end
      end

      // One log2 fraction bit per squaring
      S_LOG: begin
        mul_a = 33'(m_q);
        mul_b = 33'(m_q);
        sq = prod[61:30];
        if (sq[31]) begin
          m_d = sq[31:1];
          frac_d = {frac_q[14:0], 1'b1};
        end else begin
          m_d = sq[30:0];
          frac_d = {frac_q[14:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == ITER_LAST) begin
          state_d = S_LSCALE;
        end
      end

      S_LSCALE: begin
        lval = $signed({7'b0, frac_q}) - $signed({2'b0, sh_q, 16'b0});
        mul_a = 33'(lval);
        mul_b = 33'(DB_PER_OCT_Q16);
        e_d = 26'(prod >>> 16);
        j_d = '0;
        seg_d = '0;
        state_d = S_SRD;
      end

      S_SRD: begin
        raddr = IW'(j_q);
        state_d = S_SCMP;
      end

      // Keep the last knee whose left bound lies below the level
      S_SCMP: begin
        lb = 27'(rdata_a_q.left) <<< 7;
        segn = seg_q;
        if (27'(e_q) > lb) begin
          segn = j_q + 1'b1;
        end
        seg_d = segn;
        j_d = j_q + 1'b1;
        if ((j_q + 1'b1) == n_q) begin
          if (segn == '0) begin
            red_d = '0;
            state_d = S_GAIN;
          end else begin
            state_d = S_KRD;
          end
        end else begin
          state_d = S_SRD;
        end
      end

      S_KRD: begin
        raddr = IW'(seg_q - 1'b1);
        state_d = S_KLAT;
      end

      S_KLAT: begin
        knee_d = rdata_a_q;
        cum_d = rb_zero_q ? '0 : rdata_b_q;
        raddr = IW'(seg_q - CW'(2));
        state_d = S_PLAT;
      end

      S_PLAT: begin
        p_d = (seg_q == CW'(1)) ? '0 : rdata_a_q.slope;
        off_d = 27'(e_q) - (27'(knee_q.left) <<< 7);
        hi_b = (27'(knee_q.thr) <<< 8) + $signed({6'b0, knee_q.hw, 7'b0});
        if (27'(e_q) >= hi_b) begin
          state_d = S_ABOVE;
        end else begin
          state_d = S_QCOEF;
        end
      end

      S_ABOVE: begin
        mul_a = 33'(knee_q.slope);
        mul_b = 33'(27'(e_q) - (27'(knee_q.thr) <<< 8));
        red_d = (52'(cum_q) <<< 8) + 52'(prod >>> 14);
        state_d = S_GAIN;
      end

      S_QCOEF: begin
        mul_a = 33'(17'(knee_q.slope) - 17'(p_q));
        mul_b = 33'(knee_q.quad);
        qc_d = 36'(prod >>> 6);
        state_d = S_T1;
      end

      S_T1: begin
        mul_a = 33'(off_q);
        mul_b = {15'b0, qc_q[17:0]};
        acc_d = prod;
        state_d = S_T2;
      end

      S_T2: begin
        mul_a = 33'(off_q);
        mul_b = 33'($signed(qc_q[35:18]));
        sum = acc_q + (prod <<< 18);
        inner_d = 40'(sum >>> 24) + (40'(p_q) <<< 2);
        state_d = S_U1;
      end

      S_U1: begin
        mul_a = 33'(off_q);
        mul_b = {15'b0, inner_q[17:0]};
        acc_d = prod;
        state_d = S_U2;
      end

      S_U2: begin
        mul_a = 33'(off_q);
        mul_b = 33'($signed(inner_q[39:18]));
        sum = acc_q + (prod <<< 18);
        red_d = (52'(cum_q) <<< 8) + 52'(sum >>> 16);
        state_d = S_U3;
      end

      S_U3: begin
        mul_a = 33'(knee_q.hw);
        mul_b = 33'(p_q);
        sum = -prod;
        red_d = red_q + 52'(sum >>> 7);
        state_d = S_GAIN;
      end

      // Add makeup, report the gain, check for silence
      S_GAIN: begin
        g = (53'(makeup_q) <<< 8) + 53'(red_q);
        g_d = g;
        g8 = 45'((g + 53'sd128) >>> 8);
        if (g8 > 45'sd8388607) begin
          res_gain_d = 24'sh7FFFFF;
        end else if (g8 < -45'sd8388608) begin
          res_gain_d = -24'sd8388608;
        end else begin
          res_gain_d = g8[23:0];
        end
        res_seg_d = SEG_W'(seg_q);
        if (makeup_q <= SILENCE_Q8 || g <= SILENCE_Q16) begin
          res_sample_d = '0;
          state_d = S_DONE;
        end else begin
          state_d = S_G2;
        end
      end

      S_G2: begin
        gc = (g_q > GAIN_CLAMP) ? 32'(GAIN_CLAMP) : 32'(g_q);
        mul_a = 33'(gc);
        mul_b = 33'(OCT_PER_DB_Q20);
        g2 = 32'(prod >>> 20);
        f_d = g2[15:0];
        expo_d = 16'(g2 >>> 16);
        r_d = 32'(1 << 30);
        cnt_d = '0;
        state_d = S_EXP;
      end

      // One fraction bit a cycle through the root table
      S_EXP: begin
        mul_a = 33'(r_q);
        mul_b = 33'(EXP_ROOT[cnt_q[3:0]]);
        if (f_q[15]) begin
          r_d = 32'(prod >>> 30);
        end
        f_d = f_q << 1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == ITER_LAST) begin
          state_d = S_SCALE;
        end
      end

      S_SCALE: begin
        mul_a = 33'(smp_q);
        mul_b = 33'(r_q);
        y_d = prod;
        state_d = S_SHIFT;
      end

      // Round, shift down by the exponent, saturate
      S_SHIFT: begin
        sexp = 17'sd30 - 17'(expo_q);
        if (sexp <= 17'sd0) begin
          if (y_q == '0) begin
            res_sample_d = '0;
          end else if (y_q > 66'sd0) begin
            res_sample_d = SAMPLE_BITS'(SMAX);
          end else begin
            res_sample_d = SAMPLE_BITS'(SMIN);
          end
        end else if (sexp >= 17'sd62) begin
          res_sample_d = '0;
        end else begin
          sh6 = sexp[5:0];
          yr = (y_q + (66'sd1 <<< (sh6 - 6'd1))) >>> sh6;
          if (yr > SMAX) begin
            res_sample_d = SAMPLE_BITS'(SMAX);
          end else if (yr < SMIN) begin
            res_sample_d = SAMPLE_BITS'(SMIN);
          end else begin
            res_sample_d = SAMPLE_BITS'(yr);
          end
        end
        state_d = S_DONE;
      end

      // Hold until the output register is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_sample_d = res_sample_q;
          out_gain_d = res_gain_q;
          out_seg_d = res_seg_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      knee_count_q <= '0;
      makeup_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      knee_count_q <= knee_count_d;
      makeup_q <= makeup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d; norm_q <= norm_d; sh_q <= sh_d; cnt_q <= cnt_d; m_q <= m_d;
    frac_q <= frac_d; e_q <= e_d; j_q <= j_d; seg_q <= seg_d; n_q <= n_d; ci_q <= ci_d;
    kidx_q <= kidx_d; wk_q <= wk_d; knee_q <= knee_d; div_q <= div_d; rem_q <= rem_d;
    prev_thr_q <= prev_thr_d; prev_slope_q <= prev_slope_d; prev_cum_q <= prev_cum_d;
    cum_q <= cum_d; p_q <= p_d; off_q <= off_d; qc_q <= qc_d; acc_q <= acc_d;
    inner_q <= inner_d; red_q <= red_d; g_q <= g_d; expo_q <= expo_d; f_q <= f_d;
    r_q <= r_d; y_q <= y_d;
    res_sample_q <= res_sample_d; res_gain_q <= res_gain_d; res_seg_q <= res_seg_d;
    out_sample_q <= out_sample_d; out_gain_q <= out_gain_d; out_seg_q <= out_seg_d;
  end

  // Tables: one write and one registered read per cycle; cumulative entry zero is 0 dB
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[waddr] <= wdata_a;
    end
    if (we_b) begin
      mem_b[waddr] <= wdata_b;
    end
    rdata_a_q <= mem_a[raddr];
    rdata_b_q <= mem_b[raddr];
    rb_zero_q <= (raddr == '0);
  end

endmodule
